>>> rtl/afu_pkg.sv
// afu_pkg: shared types and constants of the activation function unit
// no dependencies; used by afu_exp, afu_div, afu_post, activation_function_unit and the testbench
`default_nettype none

package afu_pkg;

    typedef enum logic [2:0] {
        KIND_LINEAR  = 3'd0,
        KIND_SIGMOID = 3'd1,
        KIND_TANH    = 3'd2,
        KIND_RELU    = 3'd3,
        KIND_LEAKY   = 3'd4,
        KIND_ELU     = 3'd5
    } kind_t;

    // control that travels with every pipeline stage
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  deriv;
        logic  neg;
    } ctl_t;

    localparam int ADDR_W  = 3;
    localparam int ALPHA_W = 15;

    localparam logic REG_KIND  = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd4096;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;

    // horner coefficients of 2^g in Q30, one per polynomial stage
    localparam logic [31:0] EXP_COEF [0:6] = '{
        32'd165394, 32'd1431680, 32'd10327387, 32'd59597083,
        32'd257941248, 32'd744261118, 32'h4000_0000
    };

endpackage

`default_nettype wire

>>> rtl/afu_in_if.sv
// afu_in_if: request channel carrying the argument and the mode bit
// no dependencies
`default_nettype none

interface afu_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

`default_nettype wire

>>> rtl/afu_out_if.sv
// afu_out_if: result channel carrying the saturated value and its flag
// no dependencies
`default_nettype none

interface afu_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         saturated;

    modport source (output valid, output result, output saturated, input ready);
    modport sink   (input valid, input result, input saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/afu_exp.sv
// afu_exp: pipelined e^-|x| (e^-2|x| for tanh) in Q30 (range reduction, degree-6 horner, final shift)
// depends on afu_pkg
`default_nettype none

module afu_exp #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  afu_pkg::ctl_t                ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    output afu_pkg::ctl_t                ctl_out,
    output logic signed [DATA_WIDTH-1:0] x_out,
    output logic [30:0]                  e_out
);
    import afu_pkg::*;

    localparam int MW = DATA_WIDTH + 2;
    localparam int YW = DATA_WIDTH + FRAC_BITS + 33;

    logic [MW-1:0] xe;
    logic [MW-1:0] mag;
    logic [MW-1:0] emag;
    logic [YW-1:0] yq_next;
    logic [YW-1:0] yq_reg;
    ctl_t          c0_reg;
    logic signed [DATA_WIDTH-1:0] x0_reg;

    logic [YW-1:0] n_big;
    logic [29:0]   frac;
    logic [5:0]    sh_next;
    logic [30:0]   g_next;

    ctl_t                         c_reg  [7];
    logic signed [DATA_WIDTH-1:0] x_reg  [7];
    logic [31:0]                  p_reg  [7];
    logic [30:0]                  g_reg  [7];
    logic [5:0]                   sh_reg [7];
    logic                         rz_reg [7];

    logic [31:0] e_next;
    ctl_t        c_out_reg;
    logic signed [DATA_WIDTH-1:0] x_out_reg;
    logic [30:0] e_reg;

    // magnitude, doubled for tanh, times log2(e)
    always_comb
    begin
        xe      = {{2{x_in[DATA_WIDTH-1]}}, x_in};
        mag     = x_in[DATA_WIDTH-1] ? (~xe + MW'(1)) : xe;
        emag    = (ctl_in.kind == KIND_TANH) ? (mag << 1) : mag;
        yq_next = YW'(emag) * YW'(LOG2E_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
        end
        else if (en)
        begin
            c0_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yq_reg <= yq_next;
            x0_reg <= x_in;
        end
    end

    // split into integer shift and fractional part
    always_comb
    begin
        n_big   = yq_reg >> (30 + FRAC_BITS);
        frac    = yq_reg[FRAC_BITS+29:FRAC_BITS];
        sh_next = (n_big >= YW'(62)) ? 6'd63 : 6'(n_big + YW'(1));
        g_next  = Q30_ONE[30:0] - {1'b0, frac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0] <= '0;
        end
        else if (en)
        begin
            c_reg[0] <= c0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0_reg;
            p_reg[0]  <= EXP_COEF[0];
            g_reg[0]  <= g_next;
            sh_reg[0] <= sh_next;
            rz_reg[0] <= (frac == '0);
        end
    end

    for (genvar j = 1; j < 7; j++)
    begin : g_poly
        logic [62:0] prod;
        logic [31:0] p_next;

        always_comb
        begin
            prod   = {31'd0, p_reg[j-1]} * {32'd0, g_reg[j-1]};
            p_next = 32'(prod >> 30) + EXP_COEF[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[j] <= '0;
            end
            else if (en)
            begin
                c_reg[j] <= c_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j]  <= x_reg[j-1];
                p_reg[j]  <= p_next;
                g_reg[j]  <= g_reg[j-1];
                sh_reg[j] <= sh_reg[j-1];
                rz_reg[j] <= rz_reg[j-1];
            end
        end
    end

    // zero fraction gives an exact power of two
    always_comb
    begin
        e_next = rz_reg[6] ? (32'h8000_0000 >> sh_reg[6]) : (p_reg[6] >> sh_reg[6]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_out_reg <= '0;
        end
        else if (en)
        begin
            c_out_reg <= c_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out_reg <= x_reg[6];
            e_reg     <= e_next[30:0];
        end
    end

    assign ctl_out = c_out_reg;
    assign x_out   = x_out_reg;
    assign e_out   = e_reg;

endmodule

`default_nettype wire

>>> rtl/afu_div.sv
// afu_div: pipelined restoring divider, rounded 2^(F+30 or F+31) / (2^30 + e)
// depends on afu_pkg
`default_nettype none

module afu_div #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  afu_pkg::ctl_t                ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic [30:0]                  e_in,
    output afu_pkg::ctl_t                ctl_out,
    output logic signed [DATA_WIDTH-1:0] x_out,
    output logic [30:0]                  e_out,
    output logic [FRAC_BITS+1:0]         q_out
);
    import afu_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 33;

    logic [31:0]   den_next;
    logic [NW-1:0] num_next;

    ctl_t                         c_reg   [QW+1];
    logic signed [DATA_WIDTH-1:0] x_reg   [QW+1];
    logic [30:0]                  e_reg   [QW+1];
    logic [31:0]                  den_reg [QW+1];
    logic [NW-1:0]                rem_reg [QW+1];
    logic [QW-1:0]                q_reg   [QW+1];

    // numerator carries half the divisor for round half up
    always_comb
    begin
        den_next = Q30_ONE + {1'b0, e_in};
        num_next = ((ctl_in.kind == KIND_TANH) ? (NW'(1) << (FRAC_BITS + 31))
                                                : (NW'(1) << (FRAC_BITS + 30)))
                   + NW'(den_next >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg[0] <= '0;
        end
        else if (en)
        begin
            c_reg[0] <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x_in;
            e_reg[0]   <= e_in;
            den_reg[0] <= den_next;
            rem_reg[0] <= num_next;
            q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar i = 1; i <= QW; i++)
    begin : g_bit
        logic [NW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = NW'(den_reg[i-1]) << (QW - i);
            take  = (rem_reg[i-1] >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg[i] <= '0;
            end
            else if (en)
            begin
                c_reg[i] <= c_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= x_reg[i-1];
                e_reg[i]   <= e_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                rem_reg[i] <= take ? (rem_reg[i-1] - trial) : rem_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (take ? (QW'(1) << (QW - i)) : '0);
            end
        end
    end

    assign ctl_out = c_reg[QW];
    assign x_out   = x_reg[QW];
    assign e_out   = e_reg[QW];
    assign q_out   = q_reg[QW];

endmodule

`default_nettype wire

>>> rtl/afu_post.sv
// afu_post: derivative products, per-kind selection and saturation, result register
// depends on afu_pkg
`default_nettype none

module afu_post #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  afu_pkg::ctl_t                ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic [30:0]                  e_in,
    input  logic [FRAC_BITS+1:0]         q_in,
    input  logic [afu_pkg::ALPHA_W-1:0]  alpha,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         saturated
);
    import afu_pkg::*;

    localparam int VW   = FRAC_BITS + 3;
    localparam int PRW  = 2 * VW;
    localparam int RW0  = (DATA_WIDTH > FRAC_BITS + 8) ? DATA_WIDTH : FRAC_BITS + 8;
    localparam int RW   = ((RW0 > 18) ? RW0 : 18) + 1;
    localparam int K10  = DATA_WIDTH + 5;
    localparam int MW10 = DATA_WIDTH + 2;
    localparam logic [63:0] DIV10_M = ((64'd1 << K10) + 64'd9) / 64'd10;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam logic [RW-1:0] LEAKY_D = RW'((ONE_I + 5) / 10);
    localparam logic signed [VW-1:0] ONE_V = VW'(ONE_I);
    localparam logic signed [RW-1:0] ONE_R = RW'(ONE_I);
    localparam logic signed [RW-1:0] HI = RW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [RW-1:0] LO = -HI - RW'(1);

    // stage a
    logic signed [VW-1:0] qv;
    logic signed [VW-1:0] sv;
    logic signed [VW-1:0] tv;
    logic [30:0]          ev;
    logic [DATA_WIDTH:0]  mag;
    logic [DATA_WIDTH:0]  v5;
    logic [2*DATA_WIDTH+2:0] lprod;

    ctl_t                         a_ctl_reg;
    logic signed [DATA_WIDTH-1:0] a_x_reg;
    logic signed [VW-1:0]         a_val_reg;
    logic [45:0]                  a_elu_reg;
    logic [DATA_WIDTH-1:0]        a_lq_reg;

    // stage b
    logic signed [VW-1:0]         other;
    ctl_t                         b_ctl_reg;
    logic signed [DATA_WIDTH-1:0] b_x_reg;
    logic signed [VW-1:0]         b_val_reg;
    logic signed [PRW-1:0]        b_prod_reg;
    logic [15:0]                  b_elu_reg;
    logic [DATA_WIDTH-1:0]        b_lq_reg;

    // stage c
    logic signed [PRW-1:0] rf_full;
    logic signed [RW-1:0]  rf;
    logic signed [RW-1:0]  xr;
    logic signed [RW-1:0]  r;
    logic                  pos;
    logic                  valid_reg;
    logic signed [DATA_WIDTH-1:0] result_reg;
    logic                  sat_reg;

    always_comb
    begin
        qv    = $signed(VW'(q_in));
        sv    = ctl_in.neg ? (ONE_V - qv) : qv;
        tv    = ctl_in.neg ? (ONE_V - qv) : (qv - ONE_V);
        ev    = ctl_in.deriv ? e_in : (Q30_ONE[30:0] - e_in);
        mag   = x_in[DATA_WIDTH-1] ? (~{1'b1, x_in} + (DATA_WIDTH+1)'(1))
                                   : {1'b0, x_in};
        v5    = mag + (DATA_WIDTH+1)'(5);
        lprod = (2*DATA_WIDTH+3)'(v5) * (2*DATA_WIDTH+3)'(DIV10_M[MW10-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_ctl_reg <= ctl_in;
            b_ctl_reg <= a_ctl_reg;
            valid_reg <= b_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= x_in;
            a_val_reg <= (ctl_in.kind == KIND_TANH) ? tv : sv;
            a_elu_reg <= 46'(alpha) * 46'(ev);
            a_lq_reg  <= DATA_WIDTH'(lprod >> K10);
        end
    end

    assign other = (a_ctl_reg.kind == KIND_TANH) ? a_val_reg : (ONE_V - a_val_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg    <= a_x_reg;
            b_val_reg  <= a_val_reg;
            b_prod_reg <= PRW'(a_val_reg) * PRW'(other);
            b_elu_reg  <= 16'((a_elu_reg + 46'(Q30_ONE >> 1)) >> 30);
            b_lq_reg   <= a_lq_reg;
        end
    end

    always_comb
    begin
        rf_full = (b_prod_reg + (PRW'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        rf      = RW'(rf_full);
        xr      = RW'(b_x_reg);
        pos     = !b_ctl_reg.neg && (b_x_reg != '0);
        unique case (b_ctl_reg.kind)
            KIND_LINEAR:  r = b_ctl_reg.deriv ? ONE_R : xr;
            KIND_SIGMOID: r = b_ctl_reg.deriv ? rf : RW'(b_val_reg);
            KIND_TANH:    r = b_ctl_reg.deriv ? (ONE_R - rf) : RW'(b_val_reg);
            KIND_RELU:    r = !pos ? '0 : (b_ctl_reg.deriv ? ONE_R : xr);
            KIND_LEAKY:
            begin
                if (pos)
                    r = b_ctl_reg.deriv ? ONE_R : xr;
                else
                    r = b_ctl_reg.deriv ? $signed(LEAKY_D) : -$signed(RW'(b_lq_reg));
            end
            KIND_ELU:
            begin
                if (pos)
                    r = b_ctl_reg.deriv ? ONE_R : xr;
                else
                    r = b_ctl_reg.deriv ? $signed(RW'(b_elu_reg))
                                        : -$signed(RW'(b_elu_reg));
            end
            default:      r = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r > HI)
            begin
                result_reg <= HI[DATA_WIDTH-1:0];
                sat_reg    <= 1'b1;
            end
            else if (r < LO)
            begin
                result_reg <= LO[DATA_WIDTH-1:0];
                sat_reg    <= 1'b1;
            end
            else
            begin
                result_reg <= r[DATA_WIDTH-1:0];
                sat_reg    <= 1'b0;
            end
        end
    end

    assign valid     = valid_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

>>> rtl/activation_function_unit.sv
// activation_function_unit: Q4.12 by default; a request passes afu_exp, afu_div and afu_post to the result
// throughput one request per cycle while the result is not stalled; exp pipeline, one divider stage per quotient bit
// a stalled result holds the whole pipeline in place, nothing is lost or repeated
// reset clears all valid bits, activation_kind to linear and elu_alpha to 1.0
// depends on afu_pkg, afu_in_if, afu_out_if, afu_exp, afu_div, afu_post
`default_nettype none

module activation_function_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    afu_in_if.sink                      arg,
    afu_out_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import afu_pkg::*;

    kind_t               kind_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic                en;
    ctl_t                ctl_in;

    ctl_t                         exp_ctl;
    logic signed [DATA_WIDTH-1:0] exp_x;
    logic [30:0]                  exp_e;
    ctl_t                         div_ctl;
    logic signed [DATA_WIDTH-1:0] div_x;
    logic [30:0]                  div_e;
    logic [FRAC_BITS+1:0]         div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_LINEAR;
            alpha_reg <= ALPHA_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_KIND)
                kind_reg <= kind_t'(pwdata[2:0]);
            else
                alpha_reg <= pwdata[ALPHA_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_KIND)
            prdata = {29'd0, kind_reg};
        else
            prdata = {17'd0, alpha_reg};
    end

    assign pready = 1'b1;

    assign en        = !res.valid || res.ready;
    assign arg.ready = en;
    assign ctl_in    = '{valid: arg.valid, kind: kind_reg, deriv: arg.mode,
                         neg: arg.value[DATA_WIDTH-1]};

    afu_exp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_exp (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .x_in    (arg.value),
        .ctl_out (exp_ctl),
        .x_out   (exp_x),
        .e_out   (exp_e)
    );

    afu_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (exp_ctl),
        .x_in    (exp_x),
        .e_in    (exp_e),
        .ctl_out (div_ctl),
        .x_out   (div_x),
        .e_out   (div_e),
        .q_out   (div_q)
    );

    afu_post #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (div_ctl),
        .x_in      (div_x),
        .e_in      (div_e),
        .q_in      (div_q),
        .alpha     (alpha_reg),
        .valid     (res.valid),
        .result    (res.result),
        .saturated (res.saturated)
    );

endmodule

`default_nettype wire

>>> tb/activation_function_unit_tb.sv
// activation_function_unit_tb: randomized and directed test of the activation unit
// drives requests through afu_in_if, checks results against an internal Q4.12 predictor
// depends on afu_pkg, afu_in_if, afu_out_if and activation_function_unit
`timescale 1ns / 100ps

module activation_function_unit_tb;
    import afu_pkg::*;

    localparam int DW = 16;
    localparam int FB = 12;
    localparam int LATENCY = FB + 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] LOG2E = 64'd1549082005;
    localparam logic [63:0] ONE30 = 64'd1 << 30;

    typedef struct packed {
        logic signed [DW-1:0] result;
        logic                 saturated;
    } act_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    afu_in_if #(.DATA_WIDTH(DW)) arg ();
    afu_out_if #(.DATA_WIDTH(DW)) res ();

    activation_function_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .arg(arg), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    logic [2:0] cur_kind = KIND_LINEAR;
    logic [ALPHA_W-1:0] cur_alpha = ALPHA_RESET;
    act_out_t expected_results[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int sat_seen = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    logic [ALPHA_W-1:0] edges_a[4] = '{15'd0, 15'h7FFF, 15'd4096, 15'h5AA5};

    initial
    begin
        arg.valid = 1'b0;
        arg.value = '0;
        arg.mode = 1'b0;
        res.ready = 1'b0;
    end

    function automatic logic [63:0] exp_neg(input logic [63:0] mag);
        logic [63:0] yq;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] p;
        logic [63:0] coef[0:5];
        coef = '{64'd744261118, 64'd257941248, 64'd59597083, 64'd10327387,
                 64'd1431680, 64'd165394};
        yq = (mag * LOG2E) >> FB;
        n = yq >> 30;
        r = yq & (ONE30 - 1);
        if (r == 0)
            return (n >= 31) ? 64'd0 : (ONE30 >> n);
        g = ONE30 - r;
        p = coef[5];
        for (int k = 4; k >= 0; k--)
            p = ((p * g) >> 30) + coef[k];
        p = ((p * g) >> 30) + ONE30;
        if (n + 1 >= 63)
            return 64'd0;
        return p >> (n + 1);
    endfunction

    function automatic act_out_t activate(input logic signed [DW-1:0] value, input logic mode);
        longint x;
        longint one;
        longint r;
        longint s;
        longint mag;
        logic [63:0] e;
        logic [63:0] a;
        act_out_t o;
        x = value;
        one = 64'sd1 << FB;
        mag = (x < 0) ? -x : x;
        r = 0;
        case (cur_kind)
            KIND_LINEAR: r = mode ? one : x;
            KIND_SIGMOID:
            begin
                e = exp_neg(mag);
                s = longint'(((64'd1 << (FB + 30)) + ((ONE30 + e) >> 1)) / (ONE30 + e));
                if (x < 0)
                    s = one - s;
                r = mode ? longint'((s * (one - s) + (1 << (FB - 1))) >>> FB) : s;
            end
            KIND_TANH:
            begin
                e = exp_neg(mag * 2);
                s = longint'(((64'd1 << (FB + 31)) + ((ONE30 + e) >> 1)) / (ONE30 + e)) - one;
                if (x < 0)
                    s = -s;
                r = mode ? one - ((s * s + (1 << (FB - 1))) >>> FB) : s;
            end
            KIND_RELU: r = (x > 0) ? (mode ? one : x) : 0;
            KIND_LEAKY:
                if (x > 0)
                    r = mode ? one : x;
                else
                    r = mode ? (one + 5) / 10 : -((mag + 5) / 10);
            KIND_ELU:
                if (x > 0)
                    r = mode ? one : x;
                else
                begin
                    e = exp_neg(mag);
                    a = cur_alpha;
                    if (mode)
                        r = longint'((a * e + (ONE30 >> 1)) >> 30);
                    else
                        r = -longint'((a * (ONE30 - e) + (ONE30 >> 1)) >> 30);
                end
            default: r = 0;
        endcase
        o.saturated = 1'b0;
        if (r > 32767)
        begin
            r = 32767;
            o.saturated = 1'b1;
        end
        else if (r < -32768)
        begin
            r = -32768;
            o.saturated = 1'b1;
        end
        o.result = r[DW-1:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, received);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // ends any burst of requests, then waits for every result
    task automatic wait_drained();
        arg.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_kind(input logic [2:0] kind);
        wait_drained();
        write_reg(ADDR_W'(4 * REG_KIND), {29'd0, kind});
        cur_kind = kind;
    endtask

    task automatic set_alpha(input logic [ALPHA_W-1:0] alpha);
        wait_drained();
        write_reg(ADDR_W'(4 * REG_ALPHA), {17'd0, alpha});
        cur_alpha = alpha;
    endtask

    // called at a falling edge; drives one request, holding valid until accepted
    // and returning at the next falling edge with valid still high
    task automatic send_arg(input logic signed [DW-1:0] value, input logic mode);
        while ($urandom_range(99) < idle_pct)
        begin
            arg.valid <= 1'b0;
            @(negedge clk);
        end
        arg.valid <= 1'b1;
        arg.value <= value;
        arg.mode <= mode;
        @(posedge clk);
        while (!arg.ready)
            @(posedge clk);
        expected_results.push_back(activate(value, mode));
        sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
        res.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        act_out_t want;
        if ((arg.valid && arg.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && res.valid && res.ready)
        begin
            received++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", res.result, 0);
            else
            begin
                want = expected_results.pop_front();
                if (res.result !== want.result)
                    report_mismatch("result", res.result, want.result);
                if (res.saturated !== want.saturated)
                    report_mismatch("saturated", res.saturated, want.saturated);
                if (want.saturated)
                    sat_seen++;
            end
        end
    end

    always @(posedge clk)
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", expected_results.size());
            $display("FAIL activation_function_unit");
            $finish;
        end

    task automatic test_directed();
        logic signed [DW-1:0] edges[8];
        edges = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh1000,
                  16'shF000, 16'sh5555};
        for (int k = 0; k < 8; k++)
        begin
            set_kind(3'(k));
            for (int i = 0; i < 8; i++)
                send_arg(edges[i], i[0] ^ k[0]);
            send_arg(edges[$urandom_range(7)], $urandom_range(1));
        end
    endtask

    task automatic test_elu_alpha();
        set_kind(KIND_ELU);
        foreach (edges_a[i])
        begin
            set_alpha(edges_a[i]);
            send_arg(16'sh8000, 1'b0);
            send_arg(16'sh8000, 1'b1);
            send_arg(16'shFFFF, 1'b0);
            send_arg(16'shF800, 1'b1);
        end
    endtask

    task automatic test_random(input int count);
        logic signed [DW-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                set_kind(3'($urandom_range(7)));
                if ($urandom_range(2) == 0)
                    set_alpha(ALPHA_W'($urandom));
            end
            case ($urandom_range(3))
                0: v = DW'($urandom);
                1: v = DW'($signed($urandom_range(16384)) - 8192);
                2: v = DW'($signed($urandom_range(512)) - 256);
                default: v = DW'($urandom) | 16'sh8000;
            endcase
            send_arg(v, $urandom_range(1));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);
        send_arg(16'sh1234, 1'b0);
        test_directed();
        test_elu_alpha();
        idle_pct = 0;  stall_pct = 0;  test_random(400);
        idle_pct = 69; stall_pct = 0;  test_random(350);
        wait_drained();
        idle_pct = 0;  stall_pct = 69; test_random(350);
        idle_pct = 35; stall_pct = 35; test_random(350);
        idle_pct = 0;  stall_pct = 0;  test_random(200);
        set_kind(KIND_LINEAR);
        set_alpha(ALPHA_RESET);
        wait_drained();
        $display("covered %0d requests, %0d results, %0d saturated, all kinds and both modes",
                 sent, received, sat_seen);
        $display("idle and stall mixes 0/0, 69/0, 0/69, 35/35; alpha extremes written");
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS activation_function_unit");
        else
            $display("FAIL activation_function_unit");
        $finish;
    end
endmodule
